FILE: rtl/core/hcbd_pkg.sv
package hcbd_pkg;

  localparam int SIZE_DIGITS_DEF = 4;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 32;
  localparam int BUDGET_W        = 32;
  localparam int TRAIL_W         = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY     = 1'd1;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [TRAIL_W-1:0] TRAIL_LEN = 2'd2;

  typedef enum logic [1:0] {
    ST_RUN    = 2'd0,
    ST_DONE   = 2'd1,
    ST_FMTERR = 2'd2,
    ST_BUDGET = 2'd3
  } status_t;

  typedef enum logic [6:0] {
    PH_SIZE   = 7'b0000001,
    PH_LF     = 7'b0000010,
    PH_DATA   = 7'b0000100,
    PH_TRAIL  = 7'b0001000,
    PH_DONE   = 7'b0010000,
    PH_FMTERR = 7'b0100000,
    PH_BUDGET = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       new_body;
  } in_beat_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] out_byte;
    logic [1:0] status;
  } out_beat_t;

  typedef struct packed {
    logic                limit_enable;
    logic [BUDGET_W-1:0] max_body_bytes;
  } cfg_t;

  typedef struct packed {
    logic fire;
    logic adv;
  } flow_t;

  // {hit, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic [1:0] status_of(input phase_t ph);
    logic [1:0] s;
    case (ph)
      PH_SIZE, PH_LF, PH_DATA, PH_TRAIL: s = ST_RUN;
      PH_DONE:                           s = ST_DONE;
      PH_BUDGET:                         s = ST_BUDGET;
      default:                           s = ST_FMTERR;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/core/hcbd_in_stage.sv
module hcbd_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hcbd_pkg::in_beat_t in_data,
  input  logic               adv,
  output logic               s1_valid,
  output hcbd_pkg::in_beat_t s1_data
);

  logic               valid_r, valid_nxt;
  hcbd_pkg::in_beat_t data_r;
  logic               take;

  assign in_stall  = valid_r && !adv;
  assign take      = !in_stall;
  assign valid_nxt = take ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      data_r <= in_data;
    end
  end

  assign s1_valid = valid_r;
  assign s1_data  = data_r;

endmodule

FILE: rtl/core/hcbd_engine.sv
module hcbd_engine #(
  parameter int SIZE_DIGITS = hcbd_pkg::SIZE_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hcbd_pkg::flow_t     flow,
  input  hcbd_pkg::in_beat_t  s1_data,
  input  hcbd_pkg::cfg_t      cfg,
  output hcbd_pkg::out_beat_t result,
  output hcbd_pkg::phase_t    phase
);

  localparam int SIZE_W = 4 * SIZE_DIGITS;
  localparam int LP_W   = $clog2(SIZE_DIGITS + 1);
  localparam int BW     = hcbd_pkg::BUDGET_W;

  hcbd_pkg::phase_t            phase_r, phase_nxt, ph;
  logic [SIZE_W-1:0]           acc_r, acc_nxt, acc;
  logic [LP_W-1:0]             lp_r, lp_nxt, lp;
  logic [SIZE_W-1:0]           dl_r, dl_nxt, dl;
  logic [hcbd_pkg::TRAIL_W-1:0] tl_r, tl_nxt, tl;
  logic [BW-1:0]               tot_r, tot_nxt, tot;

  logic [7:0]        c;
  logic [4:0]        hx;
  logic              reached, spent, over_budget, too_big;
  logic [BW-1:0]     left;
  logic              dv;
  logic [7:0]        ob;

  always_comb begin
    c = s1_data.in_byte;
    if (s1_data.new_body) begin
      ph  = hcbd_pkg::PH_SIZE;
      acc = '0;
      lp  = '0;
      dl  = '0;
      tl  = '0;
      tot = '0;
    end else begin
      ph  = phase_r;
      acc = acc_r;
      lp  = lp_r;
      dl  = dl_r;
      tl  = tl_r;
      tot = tot_r;
    end

    hx          = hcbd_pkg::hex_decode(c);
    reached     = tot >= cfg.max_body_bytes;
    spent       = cfg.limit_enable && reached;
    left        = cfg.max_body_bytes - tot;
    over_budget = reached ? (acc != '0) : (BW'(acc) > left);
    too_big     = (SIZE_W >= 32) && acc[SIZE_W-1];

    phase_nxt = ph;
    acc_nxt   = acc;
    lp_nxt    = lp;
    dl_nxt    = dl;
    tl_nxt    = tl;
    tot_nxt   = tot;
    dv        = 1'b0;
    ob        = 8'd0;

    case (ph)
      hcbd_pkg::PH_SIZE: begin
        if (lp == '0 && spent) begin
          phase_nxt = hcbd_pkg::PH_DONE;
        end else if (c == hcbd_pkg::CHAR_CR) begin
          phase_nxt = (lp == '0) ? hcbd_pkg::PH_FMTERR : hcbd_pkg::PH_LF;
        end else if (!hx[4] || lp >= LP_W'(SIZE_DIGITS)) begin
          phase_nxt = hcbd_pkg::PH_FMTERR;
        end else begin
          acc_nxt = (acc << 4) | SIZE_W'(hx[3:0]);
          lp_nxt  = lp + LP_W'(1);
        end
      end
      hcbd_pkg::PH_LF: begin
        if (c != hcbd_pkg::CHAR_LF || too_big) begin
          phase_nxt = hcbd_pkg::PH_FMTERR;
        end else if (cfg.limit_enable && over_budget) begin
          phase_nxt = hcbd_pkg::PH_BUDGET;
        end else begin
          lp_nxt = '0;
          if (acc == '0) begin
            tl_nxt    = hcbd_pkg::TRAIL_LEN;
            phase_nxt = hcbd_pkg::PH_TRAIL;
          end else begin
            dl_nxt    = acc;
            phase_nxt = hcbd_pkg::PH_DATA;
          end
        end
      end
      hcbd_pkg::PH_DATA: begin
        dv = 1'b1;
        ob = c;
        if (tot != '1) begin
          tot_nxt = tot + BW'(1);
        end
        if (dl != '0) begin
          dl_nxt = dl - SIZE_W'(1);
        end
        if (dl_nxt == '0) begin
          tl_nxt    = hcbd_pkg::TRAIL_LEN;
          phase_nxt = hcbd_pkg::PH_TRAIL;
        end
      end
      hcbd_pkg::PH_TRAIL: begin
        if (tl != '0) begin
          tl_nxt = tl - hcbd_pkg::TRAIL_W'(1);
        end
        if (tl_nxt == '0) begin
          if (acc == '0 || spent) begin
            phase_nxt = hcbd_pkg::PH_DONE;
          end else begin
            phase_nxt = hcbd_pkg::PH_SIZE;
            acc_nxt   = '0;
            lp_nxt    = '0;
          end
        end
      end
      hcbd_pkg::PH_DONE, hcbd_pkg::PH_FMTERR, hcbd_pkg::PH_BUDGET: begin
      end
      default: begin
        phase_nxt = hcbd_pkg::PH_FMTERR;
      end
    endcase

    result.data_valid = dv;
    result.out_byte   = ob;
    result.status     = hcbd_pkg::status_of(phase_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hcbd_pkg::PH_SIZE;
      acc_r   <= '0;
      lp_r    <= '0;
      dl_r    <= '0;
      tl_r    <= '0;
      tot_r   <= '0;
    end else if (flow.fire) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      lp_r    <= lp_nxt;
      dl_r    <= dl_nxt;
      tl_r    <= tl_nxt;
      tot_r   <= tot_nxt;
    end
  end

  assign phase = phase_r;

endmodule

FILE: rtl/core/hcbd_out_stage.sv
module hcbd_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s1_valid,
  input  hcbd_pkg::out_beat_t result,
  output hcbd_pkg::flow_t     flow,
  output logic                out_valid,
  input  logic                out_stall,
  output hcbd_pkg::out_beat_t out_data
);

  logic                valid_r, valid_nxt;
  hcbd_pkg::out_beat_t data_r;

  assign flow.adv  = !valid_r || !out_stall;
  assign flow.fire = s1_valid && flow.adv;
  assign valid_nxt = flow.adv ? s1_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (flow.fire) begin
      data_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: rtl/core/http_chunked_body_decoder_unit.sv
// channel | direction | handshake          | beat
// in_     | input     | in_valid/in_stall   | in_data  (in_byte, new_body)
// out_    | output    | out_valid/out_stall | out_data (data_valid, out_byte, status)
// cfg_    | input     | cfg_we              | cfg_idx, cfg_wdata
//
// One byte per cycle sustained while out_stall is low; an input beat reaches the result beat
// through the input register, then one pass through the decode step into the result register.
// Synchronous active-low reset clears the valid flags of both stages and all decoder state.
// out_stall holds the result register; in_stall rises only when both stages are full.
module http_chunked_body_decoder_unit #(
  parameter int SIZE_DIGITS = hcbd_pkg::SIZE_DIGITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  hcbd_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output hcbd_pkg::out_beat_t                 out_data,
  input  logic                                cfg_we,
  input  logic [hcbd_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [hcbd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  hcbd_pkg::cfg_t      cfg_r;
  hcbd_pkg::flow_t     flow;
  hcbd_pkg::in_beat_t  s1_data;
  hcbd_pkg::out_beat_t result;
  hcbd_pkg::phase_t    phase;
  logic                s1_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        hcbd_pkg::CFG_LIMIT_ENABLE: cfg_r.limit_enable   <= cfg_wdata[0];
        hcbd_pkg::CFG_MAX_BODY:     cfg_r.max_body_bytes <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  hcbd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .adv      (flow.adv),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  hcbd_engine #(
    .SIZE_DIGITS (SIZE_DIGITS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .flow    (flow),
    .s1_data (s1_data),
    .cfg     (cfg_r),
    .result  (result),
    .phase   (phase)
  );

  hcbd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .result    (result),
    .flow      (flow),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_payload_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.data_valid |-> out_data.status == hcbd_pkg::ST_RUN)
    else $error("payload beat with non-running status");

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.data_valid |-> out_data.out_byte == 8'd0)
    else $error("non-payload beat carries a byte");

  a_end_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    flow.fire && !s1_data.new_body &&
    (phase == hcbd_pkg::PH_DONE || phase == hcbd_pkg::PH_FMTERR ||
     phase == hcbd_pkg::PH_BUDGET) |=> phase == $past(phase))
    else $error("terminal phase left without new_body");

endmodule
